// ----- rtl/core/tdv_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the teardrop vertex core.
// No dependencies; tdv_div, tdv_cordic and the vertex core refer to it by scoped names.
`timescale 1ns / 1ps

package tdv_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam int DEN_W = 10;

  localparam logic [7:0] REG_RADIUS = 8'd0;
  localparam logic [7:0] REG_BULGE  = 8'd1;
  localparam logic [7:0] REG_SLICES = 8'd2;
  localparam logic [7:0] REG_STACKS = 8'd3;

  localparam logic [15:0] RADIUS_RST = 16'd256;
  localparam logic [15:0] BULGE_RST  = 16'd8192;
  localparam logic [8:0]  SLICES_RST = 9'd32;
  localparam logic [8:0]  STACKS_RST = 9'd16;

  localparam logic [16:0] TEX_ONE = 17'd65536;

  localparam logic signed [17:0] TRIG_MAX = 18'sh10000;
  localparam logic signed [17:0] TRIG_MIN = 18'sh30000;
  localparam logic signed [20:0] POS_MAX  = 21'sh0FFFFF;
  localparam logic signed [20:0] POS_MIN  = 21'sh100000;
  localparam logic signed [16:0] Z_MAX    = 17'sh0FFFF;
  localparam logic signed [16:0] Z_MIN    = 17'sh10001;

  typedef logic signed [17:0] trig_t;

  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/tdv_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Uses tdv_pkg for the divisor width; the divisor must hold while words are in flight.
`timescale 1ns / 1ps

module tdv_div #(
  parameter int NW = 32
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [NW-1:0]              num,
  input  logic [tdv_pkg::DEN_W-1:0]  den,
  output logic [NW-1:0]              quot
);

  localparam int DW = tdv_pkg::DEN_W;

  logic [NW-1:0] sh_q [0:NW-1];
  logic [DW-1:0] rm_q [0:NW-1];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] sh_in;
    logic [DW-1:0] rm_in;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign sh_in = num;
      assign rm_in = '0;
    end else begin : g_next
      assign sh_in = sh_q[k-1];
      assign rm_in = rm_q[k-1];
    end

    assign trial = {rm_in, sh_in[NW-1]};
    assign take  = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (en) begin
        sh_q[k] <= {sh_in[NW-2:0], take};
        rm_q[k] <= take ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      end
    end
  end

  assign quot = sh_q[NW-1];

endmodule

// ----- rtl/core/tdv_cordic.sv -----
// Pipelined rotation-mode CORDIC giving sine and cosine of a 32-bit turn angle in Q1.16.
// Uses tdv_pkg for the gain, the arctangent table and clamp limits.
`timescale 1ns / 1ps

module tdv_cordic (
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         turn,
  output tdv_pkg::trig_t      sin_v,
  output tdv_pkg::trig_t      cos_v
);

  localparam int N  = tdv_pkg::CORDIC_STEPS;
  localparam int CW = tdv_pkg::CORDIC_W;

  logic signed [CW-1:0] xs [0:N];
  logic signed [CW-1:0] ys [0:N];
  logic signed [CW-1:0] zs [0:N];
  logic                 fl [0:N];

  logic [31:0] pre;
  logic        flip;
  logic [31:0] tf;

  assign pre  = turn + 32'h40000000;
  assign flip = pre[31];
  assign tf   = flip ? (turn ^ 32'h80000000) : turn;

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= tdv_pkg::CORDIC_GAIN;
      ys[0] <= '0;
      zs[0] <= CW'($signed(tf));
      fl[0] <= flip;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic signed [CW-1:0] ATAN = CW'(tdv_pkg::atan_turn(k));
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    assign dx = xs[k] >>> k;
    assign dy = ys[k] >>> k;

    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[k] >= 0) begin
          xs[k+1] <= xs[k] - dy;
          ys[k+1] <= ys[k] + dx;
          zs[k+1] <= zs[k] - ATAN;
        end else begin
          xs[k+1] <= xs[k] + dy;
          ys[k+1] <= ys[k] - dx;
          zs[k+1] <= zs[k] + ATAN;
        end
        fl[k+1] <= fl[k];
      end
    end
  end

  logic signed [CW-1:0] xo;
  logic signed [CW-1:0] yo;
  logic signed [19:0]   xr;
  logic signed [19:0]   yr;

  assign xo = fl[N] ? -xs[N] : xs[N];
  assign yo = fl[N] ? -ys[N] : ys[N];
  assign xr = 20'((xo + 34'sd8192) >>> 14);
  assign yr = 20'((yo + 34'sd8192) >>> 14);

  always_ff @(posedge clk) begin
    if (en) begin
      cos_v <= (xr > 20'(tdv_pkg::TRIG_MAX)) ? tdv_pkg::TRIG_MAX :
               (xr < 20'(tdv_pkg::TRIG_MIN)) ? tdv_pkg::TRIG_MIN : 18'(xr);
      sin_v <= (yr > 20'(tdv_pkg::TRIG_MAX)) ? tdv_pkg::TRIG_MAX :
               (yr < 20'(tdv_pkg::TRIG_MIN)) ? tdv_pkg::TRIG_MIN : 18'(yr);
    end
  end

endmodule

// ----- rtl/core/tdv_delay.sv -----
// Enabled shift line that delays a word alongside the main pipeline.
// No dependencies.
`timescale 1ns / 1ps

module tdv_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap [0:D-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= din;
    end
  end

  for (genvar k = 1; k < D; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        tap[k] <= tap[k-1];
      end
    end
  end

  assign dout = tap[D-1];

endmodule

// ----- rtl/core/teardrop_strip_vertex_generator_core.sv -----
// Teardrop strip vertex core: turns a strip vertex reference into a position and texcoords.
// Depends on tdv_pkg, tdv_div, tdv_cordic and tdv_delay.
//
// Use:
//   Input channel (in_valid/in_stall) carries stack_index, column and lower. A word is
//   taken on a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid/out_stall) carries pos_x, pos_y, pos_z, tex_s, tex_t from
//   an output register; a word leaves on an edge with out_valid high and out_stall low.
//   Configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) writes radius,
//   bulge scale, slice_count and stack_count; cfg_ready is always high. Write only while
//   no word is in flight.
// Pipeline: the bit-serial dividers set DIV_W stages, where DIV_W is the larger of
//   ANGLE_BITS + 10 and 26; the CORDIC units set 32, the multiplier chain 5.
// Throughput: one word per cycle while the receiver takes words.
// Reset: rst clears all pipeline valid bits and loads the register defaults
//   (radius 1.0, bulge 0.5, 32 slices, 16 stacks).
// Stall: while out_valid is high and out_stall is high the whole pipeline holds and
//   in_stall is raised; nothing is dropped or repeated.
`timescale 1ns / 1ps

module teardrop_strip_vertex_generator_core #(
  parameter int MAX_SLICES = 256,
  parameter int MAX_STACKS = 256,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         stack_index,
  input  logic [8:0]         column,
  input  logic               lower,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [20:0] pos_x,
  output logic signed [20:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic [16:0]        tex_s,
  output logic [16:0]        tex_t,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int DIV_W = (ANGLE_BITS + 10 > 26) ? ANGLE_BITS + 10 : 26;
  localparam int LAT   = DIV_W + 37;

  logic [15:0] radius;
  logic [15:0] bulge;
  logic [8:0]  slice_count;
  logic [8:0]  stack_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= tdv_pkg::RADIUS_RST;
      bulge       <= tdv_pkg::BULGE_RST;
      slice_count <= tdv_pkg::SLICES_RST;
      stack_count <= tdv_pkg::STACKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tdv_pkg::REG_RADIUS: radius      <= cfg_data;
        tdv_pkg::REG_BULGE:  bulge       <= cfg_data;
        tdv_pkg::REG_SLICES: slice_count <= cfg_data[8:0];
        tdv_pkg::REG_STACKS: stack_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld;

  assign out_valid = vld[LAT-1];
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  logic [8:0] l_eff;
  logic [8:0] s_eff;
  logic [8:0] ring;
  logic [8:0] colz;

  assign l_eff = (slice_count == 9'd0) ? 9'd1 :
                 (32'(slice_count) > 32'(MAX_SLICES)) ? 9'(MAX_SLICES) : slice_count;
  assign s_eff = (stack_count == 9'd0) ? 9'd1 :
                 (32'(stack_count) > 32'(MAX_STACKS)) ? 9'(MAX_STACKS) : stack_count;
  assign ring  = 9'(stack_index) + 9'(lower);
  assign colz  = (column == l_eff) ? 9'd0 : column;

  logic [DIV_W-1:0] num_phi, num_th, num_s, num_t;
  logic [DIV_W-1:0] q_phi, q_th, q_s, q_t;

  assign num_phi = (DIV_W'(ring) << ANGLE_BITS) + DIV_W'(s_eff);
  assign num_th  = (DIV_W'(colz) << ANGLE_BITS) + DIV_W'(l_eff >> 1);
  assign num_s   = (DIV_W'(column) << 16) + DIV_W'(l_eff >> 1);
  assign num_t   = (DIV_W'(ring) << 16) + DIV_W'(s_eff >> 1);

  tdv_div #(.NW(DIV_W)) u_div_phi (.clk, .en, .num(num_phi),
    .den({s_eff, 1'b0}), .quot(q_phi));
  tdv_div #(.NW(DIV_W)) u_div_th (.clk, .en, .num(num_th),
    .den({1'b0, l_eff}), .quot(q_th));
  tdv_div #(.NW(DIV_W)) u_div_s (.clk, .en, .num(num_s),
    .den({1'b0, l_eff}), .quot(q_s));
  tdv_div #(.NW(DIV_W)) u_div_t (.clk, .en, .num(num_t),
    .den({1'b0, s_eff}), .quot(q_t));

  logic [31:0] turn_phi, turn_th;
  tdv_pkg::trig_t sp, cp, st, ct;

  assign turn_phi = {q_phi[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
  assign turn_th  = {q_th[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};

  tdv_cordic u_cordic_phi (.clk, .en, .turn(turn_phi), .sin_v(sp), .cos_v(cp));
  tdv_cordic u_cordic_th  (.clk, .en, .turn(turn_th),  .sin_v(st), .cos_v(ct));

  logic [16:0] ts_div, tt_div, ts_d, tt_d;

  assign ts_div = (q_s > DIV_W'(tdv_pkg::TEX_ONE)) ? tdv_pkg::TEX_ONE : 17'(q_s);
  assign tt_div = (q_t > DIV_W'(tdv_pkg::TEX_ONE)) ? 17'd0 :
                  17'(tdv_pkg::TEX_ONE - 17'(q_t));

  tdv_delay #(.W(34), .D(36)) u_tex_dly (.clk, .en, .din({ts_div, tt_div}),
    .dout({ts_d, tt_d}));

  // multiplier chain
  logic [17:0]          omc;
  logic [33:0]          a_prod;
  logic signed [34:0]   z_prod;
  logic signed [17:0]   sp1, ct1, st1, ct2, st2, ct3, st3;
  logic [19:0]          a_rnd;
  logic signed [38:0]   b_prod;
  logic signed [18:0]   z_rnd;
  logic signed [16:0]   pz2, pz3, pz4;
  logic signed [22:0]   b_rnd;
  logic signed [37:0]   sf;
  logic signed [55:0]   px_prod, py_prod;
  logic signed [23:0]   px_rnd, py_rnd;

  assign omc = 18'($signed(19'd65536) - 19'(cp));

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod <= 34'(bulge) * 34'(omc);
      z_prod <= 35'($signed({1'b0, radius})) * 35'(cp);
      sp1    <= sp;
      ct1    <= ct;
      st1    <= st;
    end
  end

  assign a_rnd = 20'((a_prod + 34'd8192) >> 14);
  assign z_rnd = 19'((z_prod + 35'sd32768) >>> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      b_prod <= 39'($signed({1'b0, a_rnd})) * 39'(sp1);
      pz2    <= (z_rnd > 19'(tdv_pkg::Z_MAX)) ? tdv_pkg::Z_MAX :
                (z_rnd < 19'(tdv_pkg::Z_MIN)) ? tdv_pkg::Z_MIN : 17'(z_rnd);
      ct2    <= ct1;
      st2    <= st1;
    end
  end

  assign b_rnd = 23'((b_prod + 39'sd32768) >>> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      sf  <= 38'(40'(b_rnd) * 40'($signed({1'b0, radius})));
      pz3 <= pz2;
      ct3 <= ct2;
      st3 <= st2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_prod <= 56'(sf) * 56'(ct3);
      py_prod <= 56'(sf) * 56'(st3);
      pz4     <= pz3;
    end
  end

  assign px_rnd = 24'((px_prod + 56'sd2147483648) >>> 32);
  assign py_rnd = 24'((py_prod + 56'sd2147483648) >>> 32);

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x <= (px_rnd > 24'(tdv_pkg::POS_MAX)) ? tdv_pkg::POS_MAX :
               (px_rnd < 24'(tdv_pkg::POS_MIN)) ? tdv_pkg::POS_MIN : 21'(px_rnd);
      pos_y <= (py_rnd > 24'(tdv_pkg::POS_MAX)) ? tdv_pkg::POS_MAX :
               (py_rnd < 24'(tdv_pkg::POS_MIN)) ? tdv_pkg::POS_MIN : 21'(py_rnd);
      pos_z <= pz4;
      tex_s <= ts_d;
      tex_t <= tt_d;
    end
  end

`ifndef SYNTHESIS
  a_hold_chain: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid chain moved during a stall");
  a_take_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted word missing from first stage");
  a_counts_nonzero: assert property (@(posedge clk) disable iff (rst)
    (l_eff != 9'd0) && (s_eff != 9'd0))
    else $error("effective count is zero");
  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_W+31] |-> ((cp <= tdv_pkg::TRIG_MAX) && (cp >= tdv_pkg::TRIG_MIN)))
    else $error("cosine out of range");
`endif

endmodule

// ----- sim/teardrop_strip_vertex_generator_core_tb.sv -----
// Self-checking bench for the teardrop strip vertex core: random and directed vertex words,
// idle gaps on the input, stalls on the output, outputs compared with a behavioural predictor.
// Depends on tdv_pkg and teardrop_strip_vertex_generator_core.
`timescale 1ns / 1ps

module teardrop_strip_vertex_generator_core_tb;

  localparam int MAXL = 256;
  localparam int MAXS = 256;
  localparam int ABITS = 16;
  localparam int LATENCY = 63;
  localparam logic [7:0] REG_NONE = 8'd7;

  typedef struct packed {
    logic [7:0] stack_index;
    logic [8:0] column;
    logic       lower;
  } vertex_ref_t;

  typedef struct packed {
    logic signed [20:0] pos_x;
    logic signed [20:0] pos_y;
    logic signed [16:0] pos_z;
    logic [16:0]        tex_s;
    logic [16:0]        tex_t;
  } vertex_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] stack_index = '0;
  logic [8:0] column = '0;
  logic lower = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [20:0] pos_x, pos_y;
  logic signed [16:0] pos_z;
  logic [16:0] tex_s, tex_t;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [15:0] exp_radius, exp_bulge;
  logic [8:0]  m_slices, m_stacks;

  vertex_ref_t pending_words[$];
  vertex_out_t expected_vertices[$];
  int  mismatches = 0;
  bit  quiet = 1'b0;
  bit  hold_out = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  longint cycles = 0;

  teardrop_strip_vertex_generator_core i_dut (.*);

  always #10 clk = ~clk;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void trig_of_turn(input logic [31:0] turn, output longint sn,
                                       output longint cs);
    bit flip;
    longint x, y, z, dx, dy;
    logic [31:0] t;
    flip = ((turn + 32'h40000000) & 32'h80000000) != 0;
    t = flip ? turn - 32'h80000000 : turn;
    z = t[31] ? longint'(t) - (64'sd1 <<< 32) : longint'(t);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(tdv_pkg::atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(tdv_pkg::atan_turn(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cs = clip(round_shift(x, 14), -65536, 65536);
    sn = clip(round_shift(y, 14), -65536, 65536);
  endfunction

  function automatic logic [31:0] angle_turn(longint num, longint den);
    longint p;
    p = ((num << ABITS) + den / 2) / den;
    p &= (64'd1 << ABITS) - 1;
    return 32'(p << (32 - ABITS));
  endfunction

  function automatic longint eff_count(longint v, longint mx);
    return v == 0 ? 1 : (v > mx ? mx : v);
  endfunction

  function automatic vertex_out_t predict_vertex(vertex_ref_t w);
    vertex_out_t r;
    longint nl, ns, ring, col, sp, cp, st, ct, a, b, sf;
    logic [31:0] theta;
    nl = eff_count(longint'(m_slices), MAXL);
    ns = eff_count(longint'(m_stacks), MAXS);
    ring = longint'(w.stack_index) + longint'(w.lower);
    col = longint'(w.column);
    trig_of_turn(angle_turn(ring, 2 * ns), sp, cp);
    theta = (col == nl) ? 32'd0 : angle_turn(col, nl);
    trig_of_turn(theta, st, ct);
    a = round_shift(longint'(exp_bulge) * (65536 - cp), 14);
    b = round_shift(a * sp, 16);
    sf = b * longint'(exp_radius);
    r.pos_x = 21'(clip(round_shift(sf * ct, 32), -1048576, 1048575));
    r.pos_y = 21'(clip(round_shift(sf * st, 32), -1048576, 1048575));
    r.pos_z = 17'(clip(round_shift(longint'(exp_radius) * cp, 16), -65535, 65535));
    r.tex_s = 17'(clip(((col << 16) + nl / 2) / nl, 0, 65536));
    r.tex_t = 17'(clip(65536 - ((ring << 16) + ns / 2) / ns, 0, 65536));
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_vertices = {expected_vertices, predict_vertex({stack_index, column, lower})};
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          vertex_ref_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          {stack_index, column, lower} <= w;
          if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_vertices.size() == 0) begin
          $error("unexpected word");
          mismatches++;
        end else begin
          vertex_out_t e;
          e = expected_vertices.pop_front();
          if (pos_x !== e.pos_x) begin
            $error("pos_x exp %0d got %0d", e.pos_x, pos_x); mismatches++;
          end
          if (pos_y !== e.pos_y) begin
            $error("pos_y exp %0d got %0d", e.pos_y, pos_y); mismatches++;
          end
          if (pos_z !== e.pos_z) begin
            $error("pos_z exp %0d got %0d", e.pos_z, pos_z); mismatches++;
          end
          if (tex_s !== e.tex_s) begin
            $error("tex_s exp %0d got %0d", e.tex_s, tex_s); mismatches++;
          end
          if (tex_t !== e.tex_t) begin
            $error("tex_t exp %0d got %0d", e.tex_t, tex_t); mismatches++;
          end
        end
      end
      if (hold_out) begin
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("teardrop_strip_vertex_generator_core_tb failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tdv_pkg::REG_RADIUS: exp_radius = val;
      tdv_pkg::REG_BULGE:  exp_bulge = val;
      tdv_pkg::REG_SLICES: m_slices = val[8:0];
      tdv_pkg::REG_STACKS: m_stacks = val[8:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_vertices.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic push_word(input int s, input int c, input bit lw);
    vertex_ref_t w;
    w.stack_index = 8'(s);
    w.column = 9'(c);
    w.lower = lw;
    pending_words = {pending_words, w};
  endtask

  // mostly legal strip vertices, some out-of-range ones
  task automatic push_random(input int n);
    int ns, nl;
    for (int i = 0; i < n; i++) begin
      ns = int'(eff_count(longint'(m_stacks), MAXS));
      nl = int'(eff_count(longint'(m_slices), MAXL));
      if ($urandom_range(0, 4) == 0)
        push_word($urandom_range(0, 255), $urandom_range(0, 511),
                  1'($urandom_range(0, 1)));
      else
        push_word($urandom_range(0, ns - 1), $urandom_range(0, nl),
                  1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    exp_radius = tdv_pkg::RADIUS_RST;
    exp_bulge = tdv_pkg::BULGE_RST;
    m_slices = tdv_pkg::SLICES_RST;
    m_stacks = tdv_pkg::STACKS_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    push_word(0, 0, 0);
    push_word(0, 0, 1);
    push_word(15, 32, 1);
    push_word(15, 31, 0);
    push_word(8, 16, 0);
    push_word(16, 33, 1);
    push_word(255, 511, 1);
    push_word(255, 256, 0);
    push_word(7, 8, 1);
    push_word(3, 24, 0);
    drain();

    write_reg(tdv_pkg::REG_RADIUS, 16'hFFFF);
    write_reg(tdv_pkg::REG_BULGE, 16'hFFFF);
    write_reg(tdv_pkg::REG_SLICES, 16'd0);
    write_reg(tdv_pkg::REG_STACKS, 16'd0);
    write_reg(REG_NONE, 16'h1234);
    push_word(0, 0, 1);
    push_word(0, 1, 0);
    push_word(1, 2, 1);
    push_word(0, 0, 0);
    drain();

    write_reg(tdv_pkg::REG_SLICES, 16'h01FF);
    write_reg(tdv_pkg::REG_STACKS, 16'h01FF);
    push_word(128, 64, 0);
    push_word(255, 256, 1);
    push_word(200, 255, 1);
    push_random(150);
    drain();

    write_reg(tdv_pkg::REG_RADIUS, 16'd0);
    write_reg(tdv_pkg::REG_BULGE, 16'd0);
    write_reg(tdv_pkg::REG_SLICES, 16'd3);
    write_reg(tdv_pkg::REG_STACKS, 16'd2);
    push_random(100);
    drain();

    write_reg(tdv_pkg::REG_RADIUS, 16'($urandom));
    write_reg(tdv_pkg::REG_BULGE, 16'($urandom));
    write_reg(tdv_pkg::REG_SLICES, 16'($urandom_range(1, 256)));
    write_reg(tdv_pkg::REG_STACKS, 16'($urandom_range(1, 256)));
    hold_out = 1'b1;
    push_random(200);
    repeat (300) @(posedge clk);
    hold_out = 1'b0;
    drain();

    write_reg(tdv_pkg::REG_RADIUS, 16'($urandom));
    write_reg(tdv_pkg::REG_BULGE, 16'($urandom));
    write_reg(tdv_pkg::REG_SLICES, 16'($urandom_range(1, 256)));
    write_reg(tdv_pkg::REG_STACKS, 16'($urandom_range(1, 256)));
    push_random(250);
    drain();

    quiet = 1'b1;
    write_reg(tdv_pkg::REG_RADIUS, tdv_pkg::RADIUS_RST);
    write_reg(tdv_pkg::REG_BULGE, tdv_pkg::BULGE_RST);
    write_reg(tdv_pkg::REG_SLICES, 16'd256);
    write_reg(tdv_pkg::REG_STACKS, 16'd256);
    push_random(180);
    drain();

    if (mismatches == 0) begin
      $display("teardrop_strip_vertex_generator_core_tb passed");
    end else begin
      $display("teardrop_strip_vertex_generator_core_tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tdv_pkg.sv
rtl/core/tdv_div.sv
rtl/core/tdv_cordic.sv
rtl/core/tdv_delay.sv
rtl/core/teardrop_strip_vertex_generator_core.sv
sim/teardrop_strip_vertex_generator_core_tb.sv
